// ===== hdl/dsrs_pkg.sv =====
`default_nettype none
package dsrs_pkg;

  localparam int TABLE_DEPTH_DEF = 64;
  localparam logic [15:0] MAX_CYL_RST   = 16'd4999;
  localparam logic [15:0] START_CYL_RST = 16'd1;

  // actions
  localparam logic [1:0] ACT_LOAD   = 2'd0;
  localparam logic [1:0] ACT_SERVE  = 2'd1;
  localparam logic [1:0] ACT_REWIND = 2'd2;

  // policies
  localparam logic [1:0] MODE_FCFS  = 2'd0;
  localparam logic [1:0] MODE_SSTF  = 2'd1;
  localparam logic [1:0] MODE_LOOK  = 2'd2;
  localparam logic [1:0] MODE_CLOOK = 2'd3;

  // register indexes
  localparam logic [1:0] REG_MODE      = 2'd0;
  localparam logic [1:0] REG_MAX_CYL   = 2'd1;
  localparam logic [1:0] REG_START_CYL = 2'd2;

  // result status
  localparam logic [2:0] STAT_LOADED  = 3'd0;
  localparam logic [2:0] STAT_SERVED  = 3'd1;
  localparam logic [2:0] STAT_NONE    = 3'd2;
  localparam logic [2:0] STAT_FULL    = 3'd3;
  localparam logic [2:0] STAT_BAD_CYL = 3'd4;
  localparam logic [2:0] STAT_ORDER   = 3'd5;
  localparam logic [2:0] STAT_REWOUND = 3'd6;

  typedef struct packed {
    logic        found;
    logic [15:0] cyl;
    logic [31:0] arr;
  } cand_t;

endpackage
`default_nettype wire

// ===== hdl/disk_seek_request_scheduler.sv =====
// sequence: a load, and a serve with nothing pending, are answered straight from
//   the idle state; a rewind clears the served marks one slot a cycle; any other
//   serve makes two scans over the request memory through its single read port,
//   one slot a cycle with a flush after each scan, then one pick step
// throughput: one command at a time, next start taken once busy falls
// reset: synchronous, clears all control state; the request memories need no
//   clearing pass, only slots below the fill count are ever read
// results appear for one cycle with done high; the receiver cannot stall
`default_nettype none
module disk_seek_request_scheduler #(
  parameter int TABLE_DEPTH = dsrs_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  action,
  input  wire logic [31:0] arrive_tick,
  input  wire logic [15:0] cylinder,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [15:0] cfg_wdata,
  output logic             done,
  output logic [2:0]       status,
  output logic [5:0]       served_index,
  output logic [15:0]      served_cylinder,
  output logic [31:0]      start_time,
  output logic [31:0]      wait_ticks,
  output logic [15:0]      seek_distance,
  output logic [31:0]      total_seek,
  output logic [39:0]      total_wait,
  output logic [6:0]       pending_count
);
  import dsrs_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;
  localparam logic [1:0] ST_CLR  = 2'd3;

  // configuration
  logic [1:0]  mode;
  logic [15:0] max_cyl;
  logic [15:0] start_cyl;

  // scheduler state
  logic [1:0]    state;
  logic [CW-1:0] loaded;
  logic [CW-1:0] pending;
  logic [15:0]   head;
  logic [31:0]   cur_time;
  logic          sweep_up;
  logic [31:0]   seek_sum;
  logic [39:0]   wait_sum;
  logic [31:0]   last_arr;

  // scan sequencing
  logic          pass2;
  logic [CW-1:0] rd_cnt;
  logic          rd_vld;
  logic [AW-1:0] rd_idx;
  logic [CW-1:0] clr_cnt;

  // memory ports
  logic [47:0] tbl_rdata;
  logic        srv_rdata;
  logic        tbl_we;
  logic        srv_we;
  logic [AW-1:0] srv_waddr;
  logic        srv_wdata;

  // scan results
  logic          any_arr;
  logic [31:0]   earliest;
  cand_t         up, dn, lo, ff;
  logic [AW-1:0] up_idx, dn_idx, lo_idx, ff_idx;

  // command decode
  logic accept;
  logic full;
  logic load_ok;
  logic scan_clr;
  logic rd_more;
  logic clr_more;

  // chosen request
  cand_t         pk;
  logic [AW-1:0] pk_idx;
  logic          flip;
  logic [15:0]   du, dd;
  logic [15:0]   sk;
  logic [31:0]   wt;
  logic [32:0]   time_sum;
  logic [32:0]   seek_add;
  logic [40:0]   wait_add;
  logic [31:0]   idx_ext;
  logic [31:0]   pend_ext;
  logic [CW-1:0] pend_out;

  assign busy     = (state != ST_IDLE);
  assign accept   = start && !busy;
  assign full     = (loaded == CW'(TABLE_DEPTH));
  assign load_ok  = !full && (cylinder <= max_cyl) && (arrive_tick >= last_arr);
  assign scan_clr = accept && (action == ACT_SERVE);
  assign rd_more  = (rd_cnt < loaded);
  assign clr_more = (clr_cnt < loaded);

  // request table: arrival and cylinder, written only on a load
  assign tbl_we = accept && (action == ACT_LOAD) && load_ok;

  dsrs_ram #(.WIDTH(48), .DEPTH(TABLE_DEPTH)) u_tbl (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (loaded[AW-1:0]),
    .wdata ({arrive_tick, cylinder}),
    .raddr (rd_cnt[AW-1:0]),
    .rdata (tbl_rdata)
  );

  // served marks: cleared on load, set on serve, swept clear on rewind
  always_comb begin
    srv_we    = 1'b0;
    srv_waddr = loaded[AW-1:0];
    srv_wdata = 1'b0;
    if (tbl_we) begin
      srv_we = 1'b1;
    end else if (state == ST_FIN && pk.found) begin
      srv_we    = 1'b1;
      srv_waddr = pk_idx;
      srv_wdata = 1'b1;
    end else if (state == ST_CLR && clr_more) begin
      srv_we    = 1'b1;
      srv_waddr = clr_cnt[AW-1:0];
    end
  end

  dsrs_ram #(.WIDTH(1), .DEPTH(TABLE_DEPTH)) u_srv (
    .clk   (clk),
    .we    (srv_we),
    .waddr (srv_waddr),
    .wdata (srv_wdata),
    .raddr (rd_cnt[AW-1:0]),
    .rdata (srv_rdata)
  );

  dsrs_scan #(.TABLE_DEPTH(TABLE_DEPTH)) u_scan (
    .clk      (clk),
    .clr      (scan_clr),
    .pass2    (pass2),
    .vld      (rd_vld && state == ST_SCAN),
    .idx      (rd_idx),
    .cyl      (tbl_rdata[15:0]),
    .arr      (tbl_rdata[47:16]),
    .served   (srv_rdata),
    .cur_time (cur_time),
    .head     (head),
    .any_arr  (any_arr),
    .earliest (earliest),
    .up       (up),
    .dn       (dn),
    .lo       (lo),
    .ff       (ff),
    .up_idx   (up_idx),
    .dn_idx   (dn_idx),
    .lo_idx   (lo_idx),
    .ff_idx   (ff_idx)
  );

  // policy selection from the scan candidates
  always_comb begin
    du     = up.cyl - head;
    dd     = head - dn.cyl;
    pk     = ff;
    pk_idx = ff_idx;
    flip   = 1'b0;
    unique case (mode)
      MODE_FCFS: begin
        pk     = ff;
        pk_idx = ff_idx;
      end
      MODE_SSTF: begin
        // nearest either side, lower slot on equal distance
        if (up.found && (!dn.found || du < dd || (du == dd && up_idx < dn_idx))) begin
          pk     = up;
          pk_idx = up_idx;
        end else begin
          pk     = dn;
          pk_idx = dn_idx;
        end
      end
      MODE_LOOK: begin
        // reverse the sweep when nothing lies ahead
        if (sweep_up) begin
          flip   = !up.found;
          pk     = up.found ? up : dn;
          pk_idx = up.found ? up_idx : dn_idx;
        end else begin
          flip   = !dn.found;
          pk     = dn.found ? dn : up;
          pk_idx = dn.found ? dn_idx : up_idx;
        end
      end
      MODE_CLOOK: begin
        // wrap to the lowest arrived cylinder
        pk     = up.found ? up : lo;
        pk_idx = up.found ? up_idx : lo_idx;
      end
      default: begin
        pk     = ff;
        pk_idx = ff_idx;
      end
    endcase
    sk       = (pk.cyl >= head) ? pk.cyl - head : head - pk.cyl;
    wt       = cur_time - pk.arr;
    time_sum = {1'b0, cur_time} + {17'd0, sk};
    seek_add = {1'b0, seek_sum} + {17'd0, sk};
    wait_add = {1'b0, wait_sum} + {9'd0, wt};
    idx_ext  = 32'(pk_idx);
  end

  // pending count as shown in the beat that this cycle registers
  always_comb begin
    pend_out = pending;
    if (state == ST_IDLE && tbl_we) begin
      pend_out = pending + CW'(1);
    end else if (state == ST_FIN && pk.found) begin
      pend_out = pending - CW'(1);
    end
    pend_ext = 32'(pend_out);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      mode      <= MODE_FCFS;
      max_cyl   <= MAX_CYL_RST;
      start_cyl <= START_CYL_RST;
      loaded    <= '0;
      pending   <= '0;
      head      <= START_CYL_RST;
      cur_time  <= '0;
      sweep_up  <= 1'b1;
      seek_sum  <= '0;
      wait_sum  <= '0;
      last_arr  <= '0;
      pass2     <= 1'b0;
      rd_cnt    <= '0;
      rd_vld    <= 1'b0;
      clr_cnt   <= '0;
      done      <= 1'b0;
    end else begin
      done <= 1'b0;

      if (cfg_we) begin
        unique case (cfg_addr)
          REG_MODE:      mode      <= cfg_wdata[1:0];
          REG_MAX_CYL:   max_cyl   <= cfg_wdata;
          REG_START_CYL: start_cyl <= cfg_wdata;
          default:       ;
        endcase
      end

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            unique case (action)
              ACT_LOAD: begin
                done            <= 1'b1;
                served_index    <= '0;
                served_cylinder <= '0;
                start_time      <= '0;
                wait_ticks      <= '0;
                seek_distance   <= '0;
                total_seek      <= seek_sum;
                total_wait      <= wait_sum;
                pending_count   <= pend_ext[6:0];
                if (full) begin
                  status <= STAT_FULL;
                end else if (cylinder > max_cyl) begin
                  status <= STAT_BAD_CYL;
                end else if (arrive_tick < last_arr) begin
                  status <= STAT_ORDER;
                end else begin
                  status   <= STAT_LOADED;
                  loaded   <= loaded + CW'(1);
                  pending  <= pending + CW'(1);
                  last_arr <= arrive_tick;
                end
              end
              ACT_SERVE: begin
                if (pending == '0) begin
                  done            <= 1'b1;
                  status          <= STAT_NONE;
                  served_index    <= '0;
                  served_cylinder <= '0;
                  start_time      <= '0;
                  wait_ticks      <= '0;
                  seek_distance   <= '0;
                  total_seek      <= seek_sum;
                  total_wait      <= wait_sum;
                  pending_count   <= pend_ext[6:0];
                end else begin
                  state  <= ST_SCAN;
                  pass2  <= 1'b0;
                  rd_cnt <= '0;
                  rd_vld <= 1'b0;
                end
              end
              ACT_REWIND: begin
                head     <= start_cyl;
                cur_time <= '0;
                sweep_up <= 1'b1;
                seek_sum <= '0;
                wait_sum <= '0;
                pending  <= loaded;
                clr_cnt  <= '0;
                state    <= ST_CLR;
              end
              default: ;
            endcase
          end
        end

        ST_SCAN: begin
          // one slot read a cycle, its data reaches the scan unit in the next cycle
          rd_vld <= rd_more;
          rd_idx <= rd_cnt[AW-1:0];
          if (rd_more) begin
            rd_cnt <= rd_cnt + CW'(1);
          end else if (!rd_vld) begin
            if (!pass2) begin
              // nothing arrived yet: jump to the earliest pending arrival
              if (!any_arr) begin
                cur_time <= earliest;
              end
              pass2  <= 1'b1;
              rd_cnt <= '0;
            end else begin
              state <= ST_FIN;
            end
          end
        end

        ST_FIN: begin
          done          <= 1'b1;
          state         <= ST_IDLE;
          pending_count <= pend_ext[6:0];
          if (flip && mode == MODE_LOOK) begin
            sweep_up <= !sweep_up;
          end
          if (pk.found) begin
            status          <= STAT_SERVED;
            served_index    <= idx_ext[5:0];
            served_cylinder <= pk.cyl;
            start_time      <= cur_time;
            wait_ticks      <= wt;
            seek_distance   <= sk;
            head            <= pk.cyl;
            pending         <= pending - CW'(1);
            cur_time        <= time_sum[32] ? '1 : time_sum[31:0];
            seek_sum        <= seek_add[32] ? '1 : seek_add[31:0];
            wait_sum        <= wait_add[40] ? '1 : wait_add[39:0];
            total_seek      <= seek_add[32] ? '1 : seek_add[31:0];
            total_wait      <= wait_add[40] ? '1 : wait_add[39:0];
          end else begin
            status          <= STAT_NONE;
            served_index    <= '0;
            served_cylinder <= '0;
            start_time      <= '0;
            wait_ticks      <= '0;
            seek_distance   <= '0;
            total_seek      <= seek_sum;
            total_wait      <= wait_sum;
          end
        end

        ST_CLR: begin
          if (clr_more) begin
            clr_cnt <= clr_cnt + CW'(1);
          end else begin
            done            <= 1'b1;
            status          <= STAT_REWOUND;
            served_index    <= '0;
            served_cylinder <= '0;
            start_time      <= '0;
            wait_ticks      <= '0;
            seek_distance   <= '0;
            total_seek      <= '0;
            total_wait      <= '0;
            pending_count   <= pend_ext[6:0];
            state           <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== hdl/dsrs_ram.sv =====
`default_nettype none
module dsrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== hdl/dsrs_scan.sv =====
`default_nettype none
module dsrs_scan #(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic                           clk,
  input  wire logic                           clr,
  input  wire logic                           pass2,
  input  wire logic                           vld,
  input  wire logic [$clog2(TABLE_DEPTH)-1:0] idx,
  input  wire logic [15:0]                    cyl,
  input  wire logic [31:0]                    arr,
  input  wire logic                           served,
  input  wire logic [31:0]                    cur_time,
  input  wire logic [15:0]                    head,
  output logic                                any_arr,
  output logic [31:0]                         earliest,
  output dsrs_pkg::cand_t                     up,
  output dsrs_pkg::cand_t                     dn,
  output dsrs_pkg::cand_t                     lo,
  output dsrs_pkg::cand_t                     ff,
  output logic [$clog2(TABLE_DEPTH)-1:0]      up_idx,
  output logic [$clog2(TABLE_DEPTH)-1:0]      dn_idx,
  output logic [$clog2(TABLE_DEPTH)-1:0]      lo_idx,
  output logic [$clog2(TABLE_DEPTH)-1:0]      ff_idx
);
  import dsrs_pkg::*;

  logic live;
  logic ready;

  assign live  = vld && !served;
  assign ready = live && (arr <= cur_time);

  always_ff @(posedge clk) begin
    if (clr) begin
      any_arr  <= 1'b0;
      earliest <= '1;
      up.found <= 1'b0;
      dn.found <= 1'b0;
      lo.found <= 1'b0;
      ff.found <= 1'b0;
    end else if (!pass2) begin
      // first pass: has anything arrived, and when is the earliest arrival
      if (live) begin
        if (arr <= cur_time) begin
          any_arr <= 1'b1;
        end
        if (arr < earliest) begin
          earliest <= arr;
        end
      end
    end else begin
      // lowest unserved slot, arrived or not
      if (live && !ff.found) begin
        ff     <= '{found: 1'b1, cyl: cyl, arr: arr};
        ff_idx <= idx;
      end
      // strict compares keep the lowest slot on ties
      if (ready && cyl >= head && (!up.found || cyl < up.cyl)) begin
        up     <= '{found: 1'b1, cyl: cyl, arr: arr};
        up_idx <= idx;
      end
      if (ready && cyl <= head && (!dn.found || cyl > dn.cyl)) begin
        dn     <= '{found: 1'b1, cyl: cyl, arr: arr};
        dn_idx <= idx;
      end
      if (ready && (!lo.found || cyl < lo.cyl)) begin
        lo     <= '{found: 1'b1, cyl: cyl, arr: arr};
        lo_idx <= idx;
      end
    end
  end
endmodule
`default_nettype wire

// ===== hdl/dsrs_checker.sv =====
`default_nettype none
module dsrs_props #(
  parameter int TABLE_DEPTH = dsrs_pkg::TABLE_DEPTH_DEF
) (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic [1:0]  action,
  input wire logic        done,
  input wire logic [2:0]  status,
  input wire logic [15:0] served_cylinder,
  input wire logic [31:0] wait_ticks,
  input wire logic [15:0] seek_distance,
  input wire logic [6:0]  pending_count
);
  import dsrs_pkg::*;

  // a beat only leaves once the command has finished
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result beat while busy");

  // a load always answers in the following cycle
  a_load_one: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && action == ACT_LOAD) |=> done)
    else $error("load result missing");

  // cylinder, wait and seek distance of a non-served beat are zero
  a_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != STAT_SERVED) |->
      (served_cylinder == 16'd0 && wait_ticks == 32'd0 && seek_distance == 16'd0))
    else $error("non-served beat carries service fields");

  // no command leaves a beat before it was started
  a_cause: assert property (@(posedge clk) disable iff (rst)
    (done && !$past(busy)) |-> $past(start))
    else $error("beat without a command");
endmodule

bind disk_seek_request_scheduler dsrs_props #(.TABLE_DEPTH(TABLE_DEPTH)) u_dsrs_props (.*);
`default_nettype wire
